// ===== hw/rtl/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types and constants for the box affine transform: the box payloads,
// register indexes, reset values and the widths used along the datapath.
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned CoeffW  = 16;
  localparam int unsigned RowW    = 3 * CoeffW;
  localparam int unsigned ProdW   = CoordW + CoeffW;
  localparam int unsigned FracSh  = 14;
  localparam int unsigned SumW    = ProdW + 4;
  localparam int unsigned FloorW  = SumW - FracSh;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = RowW;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegRowX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRowY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRowZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOffY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOffZ = 3'd5;

  // identity matrix, zero translation
  localparam logic [RowW-1:0] RowXReset = 48'h0000_0000_4000;
  localparam logic [RowW-1:0] RowYReset = 48'h0000_4000_0000;
  localparam logic [RowW-1:0] RowZReset = 48'h4000_0000_0000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef coord_t [2:0]             vec3_t;

  typedef struct packed {
    coord_t in_min_x;
    coord_t in_min_y;
    coord_t in_min_z;
    coord_t in_max_x;
    coord_t in_max_y;
    coord_t in_max_z;
  } in_box_t;

  typedef struct packed {
    coord_t out_min_x;
    coord_t out_min_y;
    coord_t out_min_z;
    coord_t out_max_x;
    coord_t out_max_y;
    coord_t out_max_z;
  } out_box_t;

endpackage

// ===== hw/rtl/aat_term.sv =====
// ----------------------------------------------------------------------------
// aat_term
// Per-row term stage: for each input axis, picks the box bound that gives the
// least and the greatest product with the row coefficient, and multiplies.
// ----------------------------------------------------------------------------
module aat_term (
  input  logic [aat_pkg::RowW-1:0] coeffs,
  input  aat_pkg::vec3_t           lo,
  input  aat_pkg::vec3_t           hi,
  output aat_pkg::prod_t [2:0]     term_min,
  output aat_pkg::prod_t [2:0]     term_max
);

  always_comb begin
    logic signed [aat_pkg::CoeffW-1:0] c;
    aat_pkg::coord_t                   small_v;
    aat_pkg::coord_t                   big_v;
    aat_pkg::coord_t                   op_min;
    aat_pkg::coord_t                   op_max;
    for (int j = 0; j < 3; j++) begin
      c = signed'(coeffs[j*aat_pkg::CoeffW +: aat_pkg::CoeffW]);
      // bounds may arrive swapped, so order them first
      if (lo[j] < hi[j]) begin
        small_v = lo[j];
        big_v   = hi[j];
      end else begin
        small_v = hi[j];
        big_v   = lo[j];
      end
      // a negative coefficient flips which bound gives the least product
      if (c[aat_pkg::CoeffW-1]) begin
        op_min = big_v;
        op_max = small_v;
      end else begin
        op_min = small_v;
        op_max = big_v;
      end
      term_min[j] = aat_pkg::prod_t'(c) * aat_pkg::prod_t'(op_min);
      term_max[j] = aat_pkg::prod_t'(c) * aat_pkg::prod_t'(op_max);
    end
  end

endmodule

// ===== hw/rtl/aat_reduce.sv =====
// ----------------------------------------------------------------------------
// aat_reduce
// Sums three registered terms and the scaled offset at full precision, floors
// back to Q16.16 and saturates to 32 bits.
// ----------------------------------------------------------------------------
module aat_reduce (
  input  aat_pkg::prod_t [2:0] terms,
  input  aat_pkg::coord_t      offset,
  output aat_pkg::coord_t      result
);

  localparam int unsigned ExtP = aat_pkg::SumW - aat_pkg::ProdW;
  localparam int unsigned ExtO = aat_pkg::SumW - aat_pkg::CoordW - aat_pkg::FracSh;
  localparam int unsigned TopW = aat_pkg::FloorW - aat_pkg::CoordW + 1;

  logic signed [aat_pkg::SumW-1:0]   sum;
  logic signed [aat_pkg::FloorW-1:0] floored;
  logic [TopW-1:0]                   top_bits;

  always_comb begin
    sum = {{ExtP{terms[0][aat_pkg::ProdW-1]}}, terms[0]}
        + {{ExtP{terms[1][aat_pkg::ProdW-1]}}, terms[1]}
        + {{ExtP{terms[2][aat_pkg::ProdW-1]}}, terms[2]}
        + {{ExtO{offset[aat_pkg::CoordW-1]}}, offset, {aat_pkg::FracSh{1'b0}}};
    // dropping the low bits of a two's complement value floors it
    floored  = sum[aat_pkg::SumW-1:aat_pkg::FracSh];
    top_bits = floored[aat_pkg::FloorW-1:aat_pkg::CoordW-1];
    if (top_bits == '0 || top_bits == '1) begin
      result = floored[aat_pkg::CoordW-1:0];
    end else if (floored[aat_pkg::FloorW-1]) begin
      result = {1'b1, {(aat_pkg::CoordW-1){1'b0}}};
    end else begin
      result = {1'b0, {(aat_pkg::CoordW-1){1'b1}}};
    end
  end

endmodule

// ===== hw/rtl/aabb_affine_transform.sv =====
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Maps an axis-aligned box through a 3x4 affine matrix and returns the box
// that bounds the eight mapped corners.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+---------------------------
//   in        | in_valid / in_ready     | in_box  (aat_pkg::in_box_t)
//   out       | out_valid / out_ready   | out_box (aat_pkg::out_box_t)
//   cfg       | cfg_wr_en (no stall)    | cfg_index, cfg_data
//
// One box per cycle while out is not stalled; three register stages (input,
// term, result) lie between acceptance and out_valid.
// Per-axis min/max terms are formed before the adder, so no corner search.
// A stall on out propagates back one stage per full register; empty stages
// still take data. Synchronous reset empties the pipe and restores the
// identity matrix with zero offsets.
// ----------------------------------------------------------------------------
module aabb_affine_transform (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  aat_pkg::in_box_t             in_box,
  output logic                         out_valid,
  input  logic                         out_ready,
  output aat_pkg::out_box_t            out_box,
  input  logic                         cfg_wr_en,
  input  logic [aat_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [aat_pkg::CfgW-1:0]     cfg_data
);

  logic [2:0][aat_pkg::RowW-1:0] rows;
  aat_pkg::vec3_t                offsets;

  logic              in_v;
  aat_pkg::in_box_t  in_reg;
  logic              term_v;
  logic              term_ready;
  logic              out_ready_int;

  aat_pkg::vec3_t             lo;
  aat_pkg::vec3_t             hi;
  aat_pkg::prod_t [2:0][2:0]  tmin_next;
  aat_pkg::prod_t [2:0][2:0]  tmax_next;
  aat_pkg::prod_t [2:0][2:0]  tmin;
  aat_pkg::prod_t [2:0][2:0]  tmax;
  aat_pkg::vec3_t             res_min;
  aat_pkg::vec3_t             res_max;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= aat_pkg::RowXReset;
      rows[1] <= aat_pkg::RowYReset;
      rows[2] <= aat_pkg::RowZReset;
      offsets <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        aat_pkg::RegRowX: rows[0]    <= cfg_data;
        aat_pkg::RegRowY: rows[1]    <= cfg_data;
        aat_pkg::RegRowZ: rows[2]    <= cfg_data;
        aat_pkg::RegOffX: offsets[0] <= cfg_data[aat_pkg::CoordW-1:0];
        aat_pkg::RegOffY: offsets[1] <= cfg_data[aat_pkg::CoordW-1:0];
        aat_pkg::RegOffZ: offsets[2] <= cfg_data[aat_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow: a stage takes a beat when empty or when it drains
  assign out_ready_int = !out_valid || out_ready;
  assign term_ready    = !term_v || out_ready_int;
  assign in_ready      = !in_v || term_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v      <= 1'b0;
      term_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v <= in_valid;
      end
      if (term_ready) begin
        term_v <= in_v;
      end
      if (out_ready_int) begin
        out_valid <= term_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg <= in_box;
    end
    if (term_ready && in_v) begin
      tmin <= tmin_next;
      tmax <= tmax_next;
    end
    if (out_ready_int && term_v) begin
      out_box.out_min_x <= res_min[0];
      out_box.out_min_y <= res_min[1];
      out_box.out_min_z <= res_min[2];
      out_box.out_max_x <= res_max[0];
      out_box.out_max_y <= res_max[1];
      out_box.out_max_z <= res_max[2];
    end
  end

  assign lo = '{in_reg.in_min_z, in_reg.in_min_y, in_reg.in_min_x};
  assign hi = '{in_reg.in_max_z, in_reg.in_max_y, in_reg.in_max_x};

  for (genvar r = 0; r < 3; r++) begin : g_row
    aat_term u_term (
      .coeffs   (rows[r]),
      .lo       (lo),
      .hi       (hi),
      .term_min (tmin_next[r]),
      .term_max (tmax_next[r])
    );

    aat_reduce u_red_min (
      .terms  (tmin[r]),
      .offset (offsets[r]),
      .result (res_min[r])
    );

    aat_reduce u_red_max (
      .terms  (tmax[r]),
      .offset (offsets[r]),
      .result (res_max[r])
    );
  end

endmodule

// ===== hw/rtl/aat_checker.sv =====
// ----------------------------------------------------------------------------
// aat_checker
// Port-level checks on the box transform: reset, output hold under stall and
// the input side staying open while the result register is empty.
// ----------------------------------------------------------------------------
module aat_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input aat_pkg::out_box_t out_box
);

  // reset empties the pipe
  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // a stalled result beat holds
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_box))
    else $error("result beat changed under stall");

  // with no result waiting nothing upstream can be blocked
  a_in_open : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result register");

  // a beat taken into an empty pipe never shows up in the next cycle
  a_no_bypass : assert property (@(posedge clk) disable iff (rst)
    !out_valid && !$past(in_valid && in_ready) && !$past(in_valid && in_ready, 2)
    && !$past(out_valid) && in_valid && in_ready |=> !out_valid)
    else $error("result appeared without pipeline latency");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_box   (out_box)
);
